### rtl/ddagr_pkg.sv
package ddagr_pkg;

  localparam int MAP_W   = 64;
  localparam int MAP_H   = 64;
  localparam int FRAC    = 16;
  localparam int XW      = 6;
  localparam int YW      = 6;
  localparam int GW      = 8;   // signed walk coordinate, one cell beyond each edge
  localparam int DEPTH   = MAP_W * MAP_H;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int HEAD_W  = 22;
  localparam int DIR_W   = 19;
  localparam int DIST_W  = 32;
  localparam int COS_W   = 18;
  localparam int FISH_W  = 33;
  localparam int BUDGET  = MAP_W + MAP_H + 2;
  localparam int NSTEP_W = $clog2(BUDGET + 1);
  localparam int NUM_W   = HEAD_W + 2;
  localparam int DVD_W   = NUM_W - 1 + FRAC;
  localparam int QCNT_W  = $clog2(DVD_W);
  localparam int PROD_W  = DIST_W + 1 + COS_W;
  localparam int R_W     = PROD_W - FRAC;

  typedef enum logic [1:0] {
    REQ_CAST  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SET   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_LEFT  = 2'd1,
    ST_WDONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FACE_E = 2'd0,
    FACE_W = 2'd1,
    FACE_N = 2'd2,
    FACE_S = 2'd3
  } face_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_FIN,
    S_LEAVE,
    S_WR
  } state_e;

  typedef struct packed {
    logic    clr;
    logic    accept;
    logic    step;
    logic    div_start;
    logic    dist_load;
    logic    mul;
    logic    out_load;
    status_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_cast;
    logic in_map;
    logic wall;
    logic budget_out;
    logic div_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] map_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
    map_addr = ADDR_W'(y) * ADDR_W'(MAP_W) + ADDR_W'(x);
  endfunction

endpackage

### rtl/ddagr_ram.sv
module ddagr_ram #(
  parameter int W = 1,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ddagr_div.sv
module ddagr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ddagr_pkg::DVD_W-1:0]    dvd_i,
  input  logic [ddagr_pkg::DIR_W-1:0]    dvs_i,
  output logic                           busy_o,
  output logic [ddagr_pkg::DVD_W-1:0]    quot_o
);
  import ddagr_pkg::*;

  logic              busy_q, busy_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DIR_W-1:0]  rem_q, rem_d;
  logic [DIR_W-1:0]  dvs_q, dvs_d;
  logic [DIR_W:0]    trial;
  logic              ge;

  // one quotient bit a cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]} - {1'b0, dvs_q};
    ge     = ~trial[DIR_W];
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = QCNT_W'(DVD_W - 1);
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[DIR_W-1:0] : {rem_q[DIR_W-2:0], quo_q[DVD_W-1]};
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

### rtl/ddagr_dp.sv
module ddagr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ddagr_pkg::cmd_t               cmd_i,
  output ddagr_pkg::sts_t               sts_o,
  input  logic [1:0]                    req_type_i,
  input  logic [5:0]                    cell_x_i,
  input  logic [5:0]                    cell_y_i,
  input  logic [21:0]                   head_x_i,
  input  logic [21:0]                   head_y_i,
  input  logic signed [18:0]            dir_x_i,
  input  logic signed [18:0]            dir_y_i,
  input  logic [31:0]                   side_x_i,
  input  logic [31:0]                   side_y_i,
  input  logic [31:0]                   delta_x_i,
  input  logic [31:0]                   delta_y_i,
  input  logic signed [17:0]            cos_angle_i,
  output logic [1:0]                    status_o,
  output logic [31:0]                   perp_dist_o,
  output logic signed [32:0]            fisheye_dist_o,
  output logic [1:0]                    wall_face_o,
  output logic [5:0]                    hit_x_o,
  output logic [5:0]                    hit_y_o
);
  import ddagr_pkg::*;

  localparam logic signed [R_W-1:0] FMAX = R_W'(64'sd2147483647);
  localparam logic signed [R_W-1:0] FMIN = -(R_W'(64'sd4294967296));

  logic signed [GW-1:0]    gx_q, gx_d, gy_q, gy_d;
  logic [DIST_W-1:0]       sx_q, sx_d, sy_q, sy_d, ddx_q, ddy_q;
  logic [HEAD_W-1:0]       hx_q, hy_q;
  logic signed [DIR_W-1:0] dx_q, dy_q;
  logic signed [COS_W-1:0] cos_q;
  logic                    xside_q, xside_d, inmap_q, inmap_d;
  logic [NSTEP_W-1:0]      nstep_q;
  logic [ADDR_W:0]         clr_q;
  logic [DIST_W:0]         sum;

  logic                    neg_q, dz_q;
  logic [DIST_W-1:0]       dist_q;
  logic signed [PROD_W-1:0] prod_q;

  logic [1:0]              status_q;
  logic [DIST_W-1:0]       perp_q;
  logic signed [FISH_W-1:0] fish_q;
  logic [1:0]              face_q;
  logic [XW-1:0]           hitx_q;
  logic [YW-1:0]           hity_q;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic                    ram_wdata, ram_rdata;

  logic [XW-1:0]           grid_cell;
  logic [HEAD_W-1:0]       head;
  logic signed [DIR_W-1:0] dir;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]        an;
  logic [DIR_W-1:0]        ad;
  logic [DVD_W-1:0]        quot;
  logic                    div_busy;
  logic signed [R_W-1:0]   r;
  logic signed [R_W-1:0]   rs;

  // one dda step
  always_comb begin
    gx_d    = gx_q;
    gy_d    = gy_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    xside_d = xside_q;
    sum     = '0;
    if (sx_q < sy_q) begin
      sum     = {1'b0, sx_q} + {1'b0, ddx_q};
      sx_d    = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
      gx_d    = dx_q[DIR_W-1] ? gx_q - GW'(1) : gx_q + GW'(1);
      xside_d = 1'b1;
    end else begin
      sum     = {1'b0, sy_q} + {1'b0, ddy_q};
      sy_d    = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
      gy_d    = dy_q[DIR_W-1] ? gy_q - GW'(1) : gy_q + GW'(1);
      xside_d = 1'b0;
    end
    inmap_d = !gx_d[GW-1] && (gx_d < GW'(MAP_W)) && !gy_d[GW-1] && (gy_d < GW'(MAP_H));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      gx_q    <= GW'(cell_x_i);
      gy_q    <= GW'(cell_y_i);
      sx_q    <= side_x_i;
      sy_q    <= side_y_i;
      ddx_q   <= delta_x_i;
      ddy_q   <= delta_y_i;
      hx_q    <= head_x_i;
      hy_q    <= head_y_i;
      dx_q    <= dir_x_i;
      dy_q    <= dir_y_i;
      cos_q   <= cos_angle_i;
      nstep_q <= '0;
    end else if (cmd_i.step) begin
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      xside_q <= xside_d;
      inmap_q <= inmap_d;
      nstep_q <= nstep_q + 1'b1;
    end
  end

  // map store: clearing pass or a write request
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = map_addr(cell_x_i, cell_y_i);
    ram_wdata = (req_type_i == REQ_SET);
    if (cmd_i.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q[ADDR_W-1:0];
      ram_wdata = 1'b0;
    end else if (cmd_i.accept &&
                 (req_type_i == REQ_CLEAR || req_type_i == REQ_SET)) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = map_addr(gx_d[XW-1:0], gy_d[YW-1:0]);

  ddagr_ram #(.W(1), .D(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // divide operands for the side that was hit
  always_comb begin
    grid_cell = xside_q ? gx_q[XW-1:0] : gy_q[YW-1:0];
    head = xside_q ? hx_q : hy_q;
    dir  = xside_q ? dx_q : dy_q;
    num  = signed'(NUM_W'(grid_cell) << FRAC) - signed'(NUM_W'(head));
    if (dir[DIR_W-1]) begin
      num = num + signed'(NUM_W'(1) << FRAC);
    end
    an = num[NUM_W-1] ? (NUM_W-1)'(-num) : (NUM_W-1)'(num);
    ad = dir[DIR_W-1] ? DIR_W'(-dir) : DIR_W'(dir);
  end

  ddagr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   ({an, {FRAC{1'b0}}}),
    .dvs_i   (ad),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // fisheye: floor shift then clamp
  always_comb begin
    r  = prod_q[PROD_W-1:FRAC];
    rs = r;
    if (r > FMAX) begin
      rs = FMAX;
    end else if (r < FMIN) begin
      rs = FMIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= num[NUM_W-1] != dir[DIR_W-1];
      dz_q  <= (dir == '0);
    end
    if (cmd_i.dist_load) begin
      if (dz_q) begin
        dist_q <= '1;
      end else if (neg_q) begin
        dist_q <= '0;
      end else if (|quot[DVD_W-1:DIST_W]) begin
        dist_q <= '1;
      end else begin
        dist_q <= quot[DIST_W-1:0];
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(signed'({1'b0, dist_q}) * cos_q);
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == ST_HIT) begin
        perp_q <= dist_q;
        fish_q <= rs[FISH_W-1:0];
        if (xside_q) begin
          face_q <= (!dx_q[DIR_W-1] && dx_q != '0) ? FACE_E : FACE_W;
        end else begin
          face_q <= (!dy_q[DIR_W-1] && dy_q != '0) ? FACE_N : FACE_S;
        end
        hitx_q <= gx_q[XW-1:0];
        hity_q <= gy_q[YW-1:0];
      end else begin
        perp_q <= '0;
        fish_q <= '0;
        face_q <= '0;
        hitx_q <= '0;
        hity_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.clr_last   = (clr_q[ADDR_W-1:0] == ADDR_W'(DEPTH - 1));
    sts_o.req_cast   = (req_type_i == REQ_CAST);
    sts_o.in_map     = inmap_q;
    sts_o.wall       = ram_rdata;
    sts_o.budget_out = (nstep_q == NSTEP_W'(BUDGET));
    sts_o.div_busy   = div_busy;
  end

  assign status_o       = status_q;
  assign perp_dist_o    = perp_q;
  assign fisheye_dist_o = fish_q;
  assign wall_face_o    = face_q;
  assign hit_x_o        = hitx_q;
  assign hit_y_o        = hity_q;

endmodule

### rtl/ddagr_ctrl.sv
module ddagr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ddagr_pkg::sts_t  sts_i,
  output ddagr_pkg::cmd_t  cmd_o
);
  import ddagr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    cmd_o.out_kind = ST_HIT;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.req_cast ? S_STEP : S_WR;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (!sts_i.in_map) begin
          state_d = S_LEAVE;
        end else if (sts_i.wall) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (sts_i.budget_out) begin
          state_d = S_LEAVE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.dist_load = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_HIT;
          state_d = S_IDLE;
        end
      end
      S_LEAVE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_LEFT;
          state_d = S_IDLE;
        end
      end
      S_WR: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_WDONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/dda_grid_wall_raycast.sv
// dda grid ray caster over a 64 x 64 wall bitmap
// input channel: in_valid_i / in_stall_o with one request per transfer.
//   req_type 0 casts a ray, 1 clears a map cell, 2 sets a map cell as wall,
//   3 does nothing. every request gives exactly one result.
// output channel: out_valid_o / out_stall_i; status 0 wall hit, 1 ray left
//   the map (or ran out of steps), 2 map write done.
// after reset the map store is swept clean, one cell a cycle, while
//   in_stall_o stays high.
// a map write result goes from the write state to the output register. a cast
//   walks grid steps, each a step and then a check of the registered map
//   read, at most 130 steps. a ray off the map is loaded from the leave state;
//   a hit first runs the bit-serial divider, then the distance load, the
//   multiply and the output.
// one request is worked at a time; a finished result sits in the output
//   register, and the next request is taken while it waits. a stalled
//   receiver holds the result and the block waits before loading another.
module dda_grid_wall_raycast (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic [21:0]        head_x_i,
  input  logic [21:0]        head_y_i,
  input  logic signed [18:0] dir_x_i,
  input  logic signed [18:0] dir_y_i,
  input  logic [31:0]        side_x_i,
  input  logic [31:0]        side_y_i,
  input  logic [31:0]        delta_x_i,
  input  logic [31:0]        delta_y_i,
  input  logic signed [17:0] cos_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        perp_dist_o,
  output logic signed [32:0] fisheye_dist_o,
  output logic [1:0]         wall_face_o,
  output logic [5:0]         hit_x_o,
  output logic [5:0]         hit_y_o
);
  import ddagr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: clear sweep, walk, divide, multiply, result handoff
  ddagr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // map store, walk registers, divider, fisheye multiply, output register
  ddagr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .head_x_i       (head_x_i),
    .head_y_i       (head_y_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .side_x_i       (side_x_i),
    .side_y_i       (side_y_i),
    .delta_x_i      (delta_x_i),
    .delta_y_i      (delta_y_i),
    .cos_angle_i    (cos_angle_i),
    .status_o       (status_o),
    .perp_dist_o    (perp_dist_o),
    .fisheye_dist_o (fisheye_dist_o),
    .wall_face_o    (wall_face_o),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o)
  );

  // no request is taken while the map is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> in_stall_o)
    else $error("request taken during map sweep");

  // a result is never loaded over one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.out_load)
    else $error("pending result overwritten");

  // a miss or a write carries no distance or cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_HIT) |->
      (perp_dist_o == '0 && fisheye_dist_o == '0 && hit_x_o == '0 && hit_y_o == '0))
    else $error("non-hit result with payload");

  // the divider only starts when the walk has stopped on a wall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (sts.wall && sts.in_map && !sts.div_busy))
    else $error("divider started without a hit");

endmodule

### test/dda_grid_wall_raycast_test.sv
module dda_grid_wall_raycast_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ddagr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [5:0] cell_x_i = '0, cell_y_i = '0;
  logic [21:0] head_x_i = '0, head_y_i = '0;
  logic signed [18:0] dir_x_i = '0, dir_y_i = '0;
  logic [31:0] side_x_i = '0, side_y_i = '0, delta_x_i = '0, delta_y_i = '0;
  logic signed [17:0] cos_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [31:0] perp_dist_o;
  logic signed [32:0] fisheye_dist_o;
  logic [1:0] wall_face_o;
  logic [5:0] hit_x_o, hit_y_o;

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  dda_grid_wall_raycast DUT (.*);

  // one request as the sender sees it
  typedef struct {
    logic [1:0] req;
    logic [5:0] cx, cy;
    logic [21:0] hx, hy;
    logic signed [18:0] dx, dy;
    logic [31:0] sx, sy, ddx, ddy;
    logic signed [17:0] cs;
  } ray_req_t;

  // one answer of the block
  typedef struct {
    logic [1:0] status;
    logic [31:0] perp;
    logic [32:0] fish;
    logic [1:0] face;
    logic [5:0] hx, hy;
  } ray_res_t;

  // directed rows: a typed-in answer is used where chk is set
  typedef struct {
    ray_req_t r;
    bit chk;
    ray_res_t exp_res;
  } dir_row_t;

  ray_res_t pending_answers[$];
  bit wall_bits[DEPTH];
  int errors = 0;
  int casts_sent = 0, writes_sent = 0, hits_seen = 0, lefts_seen = 0;
  int idle_pct = 18;
  int watchdog = 0;

  // saturating unsigned 32-bit add
  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // perpendicular distance from the hit grid line, quotient truncated toward zero
  function automatic logic [31:0] wall_distance(longint line_cell, longint head, bit back,
                                                longint dir);
    longint num, an, ad;
    longint unsigned q;
    num = (line_cell <<< FRAC) - head;
    if (back) num += (64'sd1 <<< FRAC);
    if (dir == 0) return 32'hFFFF_FFFF;
    an = num < 0 ? -num : num;
    ad = dir < 0 ? -dir : dir;
    q = longint'(an << FRAC) / ad;
    if ((num < 0) != (dir < 0)) return 32'd0;
    return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // distance times cosine, floor shift, clamp to -2^32 .. 2^31 - 1 (33-bit signed result)
  function automatic logic [32:0] cos_scaled(logic [31:0] d, longint c);
    longint p, rr;
    p = longint'({32'd0, d}) * c;
    rr = p >>> FRAC;
    if (rr > 64'sh0_FFFF_FFFF / 2) rr = 64'sh0_FFFF_FFFF / 2;
    if (rr < -(64'sd1 <<< 32)) rr = -(64'sd1 <<< 32);
    return rr[32:0];
  endfunction

  // walks the ray over the local map copy, or applies a map write
  function automatic ray_res_t predict_answer(ray_req_t r);
    ray_res_t o;
    longint gx, gy, stx, sty;
    logic [31:0] sx, sy;
    bit xs, hit;
    o = '{default: '0};
    if (r.req != REQ_CAST) begin
      if (r.req == REQ_CLEAR || r.req == REQ_SET)
        wall_bits[r.cy * MAP_W + r.cx] = (r.req == REQ_SET);
      o.status = ST_WDONE;
      return o;
    end
    gx = r.cx; gy = r.cy;
    stx = r.dx < 0 ? -1 : 1;
    sty = r.dy < 0 ? -1 : 1;
    sx = r.sx; sy = r.sy;
    xs = 0; hit = 0;
    for (int n = 0; n < BUDGET; n++) begin
      if (sx < sy) begin
        sx = sat_sum(sx, r.ddx); gx += stx; xs = 1;
      end else begin
        sy = sat_sum(sy, r.ddy); gy += sty; xs = 0;
      end
      if (gx < 0 || gx >= MAP_W || gy < 0 || gy >= MAP_H) break;
      if (wall_bits[gy * MAP_W + gx]) begin
        hit = 1;
        break;
      end
    end
    if (!hit) begin
      o.status = ST_LEFT;
      return o;
    end
    o.status = ST_HIT;
    o.perp = xs ? wall_distance(gx, r.hx, stx < 0, r.dx)
                : wall_distance(gy, r.hy, sty < 0, r.dy);
    o.fish = cos_scaled(o.perp, r.cs);
    o.face = xs ? (r.dx > 0 ? FACE_E : FACE_W) : (r.dy > 0 ? FACE_N : FACE_S);
    o.hx = gx[5:0];
    o.hy = gy[5:0];
    return o;
  endfunction

  // random ray, mostly well-formed, mostly from a head inside the start cell
  function automatic ray_req_t random_ray();
    ray_req_t r;
    r.req = REQ_CAST;
    r.cx = 6'($urandom_range(0, 63));
    r.cy = 6'($urandom_range(0, 63));
    r.hx = {r.cx, 16'($urandom)};
    r.hy = {r.cy, 16'($urandom)};
    if ($urandom_range(0, 9) == 0) begin
      r.hx = 22'($urandom); r.hy = 22'($urandom);
    end
    case ($urandom_range(0, 5))
      0: r.dx = 19'sd131072;
      1: r.dx = -19'sd131072;
      2: r.dx = 0;
      default: r.dx = $signed(19'($urandom_range(0, 262143))) >>> $urandom_range(0, 2);
    endcase
    case ($urandom_range(0, 5))
      0: r.dy = 19'sd131072;
      1: r.dy = -19'sd131072;
      2: r.dy = 0;
      default: r.dy = $signed(19'($urandom_range(0, 262143))) >>> $urandom_range(0, 2);
    endcase
    r.ddx = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0008_0000);
    r.ddy = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0008_0000);
    r.sx = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000);
    r.sy = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000);
    if ($urandom_range(0, 15) == 0) r.sx = 32'hFFFF_FFFF;
    r.cs = $urandom_range(0, 7) == 0 ? 18'($urandom)
                                     : 18'($signed($urandom_range(0, 131072)) - 65536);
    return r;
  endfunction

  function automatic ray_req_t map_write(logic [1:0] kind, int x, int y);
    ray_req_t r;
    r = '{default: '0};
    r.req = kind; r.cx = 6'(x); r.cy = 6'(y);
    r.hx = 22'($urandom); r.hy = 22'($urandom);
    r.dx = 19'($urandom); r.dy = 19'($urandom);
    r.sx = $urandom; r.sy = $urandom; r.ddx = $urandom; r.ddy = $urandom;
    r.cs = 18'($urandom);
    return r;
  endfunction

  // hands one request to the block; expected answer queued at acceptance
  task automatic send_request(ray_req_t r, bit chk, ray_res_t typed);
    ray_res_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_type_i <= r.req; cell_x_i <= r.cx; cell_y_i <= r.cy;
    head_x_i <= r.hx; head_y_i <= r.hy; dir_x_i <= r.dx; dir_y_i <= r.dy;
    side_x_i <= r.sx; side_y_i <= r.sy; delta_x_i <= r.ddx; delta_y_i <= r.ddy;
    cos_angle_i <= r.cs;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_answer(r);
    pending_answers.push_back(chk ? typed : p);
    if (r.req == REQ_CAST) casts_sent++; else writes_sent++;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < idle_pct);
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    ray_res_t e;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d answers pending", pending_answers.size());
      $display("dda_grid_wall_raycast: mismatch");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $error("answer with nothing pending, status %0d", status_o);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (status_o == ST_HIT) hits_seen++;
        if (status_o == ST_LEFT) lefts_seen++;
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o); errors++;
        end
        if (perp_dist_o !== e.perp) begin
          $error("perp_dist expected %0h actual %0h", e.perp, perp_dist_o); errors++;
        end
        if (fisheye_dist_o !== e.fish) begin
          $error("fisheye_dist expected %0h actual %0h", e.fish, fisheye_dist_o);
          errors++;
        end
        if (wall_face_o !== e.face) begin
          $error("wall_face expected %0d actual %0d", e.face, wall_face_o); errors++;
        end
        if (hit_x_o !== e.hx) begin
          $error("hit_x expected %0d actual %0d", e.hx, hit_x_o); errors++;
        end
        if (hit_y_o !== e.hy) begin
          $error("hit_y expected %0d actual %0d", e.hy, hit_y_o); errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ray_res_t none;
    ray_req_t r;
    int n, k;
    none = '{default: '0};
    foreach (wall_bits[i]) wall_bits[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    // cast over an empty map leaves it
    r = random_ray(); r.cx = 0; r.cy = 0; r.dx = -19'sd131072; r.sx = 0; r.sy = 1;
    row.r = r; row.chk = 1; row.exp_res = '{status: ST_LEFT, default: '0}; rows.push_back(row);
    // corner writes, field extremes
    row.chk = 1; row.exp_res = '{status: ST_WDONE, default: '0};
    row.r = map_write(REQ_SET, 63, 63); rows.push_back(row);
    row.r = map_write(REQ_SET, 0, 0); rows.push_back(row);
    row.r = map_write(REQ_SET, 5, 3); rows.push_back(row);
    row.r = map_write(REQ_SET, 3, 5); rows.push_back(row);
    row.r = map_write(REQ_NONE, 7, 7); rows.push_back(row);
    // east hit: step x from cell (3,3)
    row.chk = 0; row.exp_res = none;
    r = random_ray(); r.cx = 3; r.cy = 3; r.hx = {6'd3, 16'h8000}; r.hy = {6'd3, 16'h8000};
    r.dx = 19'sd65536; r.dy = 0; r.sx = 32'h8000; r.sy = 32'hFFFF_FFFF;
    r.ddx = 32'h10000; r.ddy = 32'hFFFF_FFFF; r.cs = 18'sd65536;
    row.r = r; rows.push_back(row);
    // north hit: step y with zero x direction
    r.dx = 0; r.dy = 19'sd131072; r.sx = 32'hFFFF_FFFF; r.sy = 32'h4000;
    r.ddx = 32'hFFFF_FFFF; r.ddy = 32'h8000; r.cs = -18'sd65536;
    row.r = r; rows.push_back(row);
    // west hit into (0,0) along row 0
    r.cx = 4; r.cy = 0; r.hx = {6'd4, 16'h0100}; r.dx = -19'sd131072; r.dy = 0;
    r.sx = 0; r.sy = 32'hFFFF_FFFF; r.cs = 18'sd1;
    row.r = r; rows.push_back(row);
    // south hit into (0,0) along column 0
    r.cx = 0; r.cy = 6; r.hy = {6'd6, 16'hFFFF}; r.dx = 0; r.dy = -19'sd1;
    r.sx = 32'hFFFF_FFFF; r.sy = 0; r.cs = -18'sd1;
    row.r = r; rows.push_back(row);
    // head far from the cell gives a large positive quotient
    r.hy = 22'h3F_FFFF; r.dy = -19'sd131072; row.r = r; rows.push_back(row);
    // clear the corner, the same ray leaves the map
    row.r = map_write(REQ_CLEAR, 0, 0); rows.push_back(row);
    row.r = r; rows.push_back(row);
    // equal side distances step along y
    r = random_ray(); r.cx = 62; r.cy = 62; r.sx = 5; r.sy = 5; r.dx = 19'sd4;
    r.dy = 19'sd4; r.ddx = 1; r.ddy = 10; row.r = r; rows.push_back(row);
    foreach (rows[i]) send_request(rows[i].r, rows[i].chk, rows[i].exp_res);

    // random part: writes grow a map, casts walk it
    for (n = 0; n < 1950; n++) begin
      if (n == 300) idle_pct = 0;
      if (n == 600) idle_pct = 18;
      if (n == 1000) begin
        // hold off until every answer is in
        in_valid_i <= 1'b0;
        wait (pending_answers.size() == 0);
        @(posedge clk_i);
      end
      k = $urandom_range(0, 99);
      if (k < 30) r = map_write($urandom_range(0, 5) == 0 ? REQ_CLEAR : REQ_SET,
                                $urandom_range(0, 63), $urandom_range(0, 63));
      else if (k < 33) r = map_write(2'($urandom_range(1, 3)), $urandom_range(0, 63),
                                     $urandom_range(0, 63));
      else r = random_ray();
      send_request(r, 0, none);
    end
    in_valid_i <= 1'b0;

    wait (pending_answers.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("sent %0d casts and %0d map writes; %0d wall hits, %0d rays off the map",
             casts_sent, writes_sent, hits_seen, lefts_seen);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("dda_grid_wall_raycast: match");
    end else begin
      $display("dda_grid_wall_raycast: mismatch");
    end
    $finish;
  end
endmodule
